[rtl/assert_macros.svh]
// Assertion macros used by the stepper core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/arbvs_pkg.sv]
// Types, codes and helper functions of the auto-repeat value stepper.
`timescale 1ns / 1ps
package arbvs_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TimerW = 17;
  localparam int unsigned OpW    = 4;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 40;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

  // Reset values of the configuration registers.
  localparam logic signed [ValueW-1:0] MinReset    = 32'sd0;
  localparam logic signed [ValueW-1:0] MaxReset    = 32'sd6553600;
  localparam logic signed [ValueW-1:0] StepReset   = 32'sd65536;
  localparam logic [MsW-1:0]           DelayReset  = 16'd500;
  localparam logic [MsW-1:0]           PeriodReset = 16'd50;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 4'd0,
    OP_UP        = 4'd1,
    OP_DOWN      = 4'd2,
    OP_HOME      = 4'd3,
    OP_END       = 4'd4,
    OP_HOLD_UP   = 4'd5,
    OP_HOLD_DOWN = 4'd6,
    OP_RELEASE   = 4'd7,
    OP_WRITE     = 4'd8,
    OP_DISABLE   = 4'd9,
    OP_OTHER     = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    REG_MIN    = 3'd0,
    REG_MAX    = 3'd1,
    REG_STEP   = 3'd2,
    REG_DELAY  = 3'd3,
    REG_PERIOD = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } hold_dir_e;

  typedef struct packed {
    logic signed [ValueW-1:0] min_value;
    logic signed [ValueW-1:0] max_value;
    logic signed [ValueW-1:0] step_size;
    logic [MsW-1:0]           initial_delay_ms;
    logic [MsW-1:0]           repeat_period_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [ValueW-1:0] held_value;
    hold_dir_e                hold_dir;
    logic [TimerW-1:0]        hold_timer;
    logic                     repeating;
    logic                     disabled;
  } state_t;

  typedef struct packed {
    logic                     status;
    logic                     touched;
    logic                     value_changed;
    logic signed [ValueW-1:0] current_value;
  } result_t;

  // Lower bound first, then upper bound, so a crossed pair resolves to max.
  function automatic logic signed [ValueW-1:0] clamp_value(
    input logic signed [ValueW-1:0] v,
    input logic signed [ValueW-1:0] lo,
    input logic signed [ValueW-1:0] hi
  );
    logic signed [ValueW-1:0] t;
    t = (v < lo) ? lo : v;
    return (t > hi) ? hi : t;
  endfunction

endpackage

[rtl/arbvs_cfg_regs.sv]
// APB register file holding bounds, step size and repeat timing.
`timescale 1ns / 1ps
module arbvs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arbvs_pkg::AddrW-1:0]   paddr,
  input  logic [arbvs_pkg::DataW-1:0]   pwdata,
  output logic [arbvs_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  output arbvs_pkg::cfg_t               cfg_o
);
  import arbvs_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MIN:    cfg_d.min_value        = pwdata;
        REG_MAX:    cfg_d.max_value        = pwdata;
        REG_STEP:   cfg_d.step_size        = pwdata;
        REG_DELAY:  cfg_d.initial_delay_ms = pwdata[MsW-1:0];
        REG_PERIOD: cfg_d.repeat_period_ms = pwdata[MsW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN:    prdata = cfg_q.min_value;
      REG_MAX:    prdata = cfg_q.max_value;
      REG_STEP:   prdata = cfg_q.step_size;
      REG_DELAY:  prdata = {{(DataW-MsW){1'b0}}, cfg_q.initial_delay_ms};
      REG_PERIOD: prdata = {{(DataW-MsW){1'b0}}, cfg_q.repeat_period_ms};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_value        <= MinReset;
      cfg_q.max_value        <= MaxReset;
      cfg_q.step_size        <= StepReset;
      cfg_q.initial_delay_ms <= DelayReset;
      cfg_q.repeat_period_ms <= PeriodReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/arbvs_event_unit.sv]
// Single-pass event logic: next stepper state and the result of one request.
`timescale 1ns / 1ps
module arbvs_event_unit (
  input  arbvs_pkg::cfg_t                   cfg_i,
  input  arbvs_pkg::state_t                 state_i,
  input  arbvs_pkg::op_e                    op_i,
  input  logic [arbvs_pkg::MsW-1:0]         elapsed_ms_i,
  input  logic signed [arbvs_pkg::ValueW-1:0] write_value_i,
  input  logic                              disable_flag_i,
  output arbvs_pkg::state_t                 state_o,
  output arbvs_pkg::result_t                result_o
);
  import arbvs_pkg::*;

  logic signed [ValueW-1:0] cur;
  logic signed [ValueW:0]   sum;
  logic signed [ValueW-1:0] sum_sat;
  logic signed [ValueW-1:0] stepped;
  logic                     step_up;
  logic [MsW-1:0]           thr;
  logic [TimerW:0]          t_raw;
  logic [TimerW-1:0]        t_sat;
  logic                     fire;
  logic                     dis;

  // Bounds may have moved since the last request, so re-clamp first.
  assign cur = clamp_value(state_i.held_value, cfg_i.min_value, cfg_i.max_value);
  assign dis = state_i.disabled;

  // One shared stepper serves plain steps, holds and repeats.
  assign step_up = (op_i == OP_UP) || (op_i == OP_HOLD_UP) ||
                   ((op_i == OP_TICK) && (state_i.hold_dir == DIR_UP));
  assign sum = step_up ? ({cur[ValueW-1], cur} + {cfg_i.step_size[ValueW-1], cfg_i.step_size})
                       : ({cur[ValueW-1], cur} - {cfg_i.step_size[ValueW-1], cfg_i.step_size});
  always_comb begin
    if (sum[ValueW] != sum[ValueW-1]) begin
      sum_sat = sum[ValueW] ? {1'b1, {(ValueW-1){1'b0}}} : {1'b0, {(ValueW-1){1'b1}}};
    end else begin
      sum_sat = sum[ValueW-1:0];
    end
  end
  assign stepped = clamp_value(sum_sat, cfg_i.min_value, cfg_i.max_value);

  // Hold timer accumulates and saturates; threshold depends on repeat phase.
  assign thr   = state_i.repeating ? cfg_i.repeat_period_ms : cfg_i.initial_delay_ms;
  assign t_raw = {1'b0, state_i.hold_timer} + {{(TimerW+1-MsW){1'b0}}, elapsed_ms_i};
  assign t_sat = t_raw[TimerW] ? TimerMax : t_raw[TimerW-1:0];
  assign fire  = t_sat >= {{(TimerW-MsW){1'b0}}, thr};

  always_comb begin
    state_o            = state_i;
    state_o.held_value = cur;
    result_o           = '0;
    case (op_i)
      OP_TICK: begin
        if (dis) begin
          result_o.status = 1'b1;
        end else if (state_i.hold_dir != DIR_NONE) begin
          if (fire) begin
            state_o.hold_timer = '0;
            state_o.repeating  = 1'b1;
            state_o.held_value = stepped;
          end else begin
            state_o.hold_timer = t_sat;
          end
        end
      end
      OP_UP, OP_DOWN: begin
        if (dis) begin
          result_o.status = 1'b1;
        end else begin
          result_o.touched   = 1'b1;
          state_o.held_value = stepped;
        end
      end
      OP_HOME, OP_END: begin
        if (!dis) begin
          result_o.touched   = 1'b1;
          state_o.held_value = clamp_value((op_i == OP_HOME) ? cfg_i.min_value
                                                             : cfg_i.max_value,
                                           cfg_i.min_value, cfg_i.max_value);
        end
      end
      OP_HOLD_UP, OP_HOLD_DOWN: begin
        if (dis) begin
          result_o.status = 1'b1;
        end else begin
          state_o.hold_dir   = (op_i == OP_HOLD_UP) ? DIR_UP : DIR_DOWN;
          state_o.hold_timer = '0;
          state_o.repeating  = 1'b0;
          state_o.held_value = stepped;
        end
      end
      OP_RELEASE: begin
        state_o.hold_dir   = DIR_NONE;
        state_o.hold_timer = '0;
        state_o.repeating  = 1'b0;
      end
      OP_WRITE: begin
        state_o.held_value = clamp_value(write_value_i, cfg_i.min_value, cfg_i.max_value);
      end
      OP_DISABLE: begin
        state_o.disabled = disable_flag_i;
        if (disable_flag_i) begin
          state_o.hold_dir   = DIR_NONE;
          state_o.hold_timer = '0;
          state_o.repeating  = 1'b0;
        end
      end
      OP_OTHER: begin
        result_o.touched = !dis;
      end
      default: begin
        state_o.held_value = cur;
      end
    endcase
    result_o.current_value = state_o.held_value;
    result_o.value_changed = state_o.held_value != state_i.held_value;
  end

endmodule

[rtl/auto_repeat_bounded_value_stepper_core.sv]
// Top level of the auto-repeat bounded value stepper.
`timescale 1ns / 1ps
// Usage:
// The block holds one signed Q16.16 value kept inside [min_value, max_value].
// Each request on the slave stream is one event (tick, step, home, end, hold,
// release, write, set disable, other); tuser carries the event code. Every
// request yields exactly one result on the master stream: the value after the
// event and the changed, touched and status flags.
// Bounds, step size and the repeat delays are set through the APB port; the user
// must write them only while no request is in flight, as the block does not enforce it.
// From acceptance the request waits in the input register while the event logic
// computes state and result in a single pass, and both are written into the
// state and result registers when the request advances.
// Throughput is one request per cycle while the receiver takes results, set by
// that single pass through the shared adder, saturation and clamp.
// When the receiver stalls, the result register holds its request and the
// input register takes one more; after that tready drops until the result is
// taken. At reset the value is 0, no hold is armed, the block is enabled and
// the registers return to 0, 100.0, 1.0, 500 ms and 50 ms.
`include "assert_macros.svh"
module auto_repeat_bounded_value_stepper_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input requests.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: elapsed_ms[15:0], write_value[47:16], disable_flag[48], zero pad[55:49]
  input  logic [arbvs_pkg::InTdataW-1:0]      s_axis_tdata,
  // tuser: op[3:0]
  input  logic [arbvs_pkg::OpW-1:0]           s_axis_tuser,
  // Results.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: current_value[31:0], value_changed[32], touched[33], status[34],
  // zero pad[39:35]
  output logic [arbvs_pkg::OutTdataW-1:0]     m_axis_tdata,
  // Configuration.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [arbvs_pkg::AddrW-1:0]         paddr,
  input  logic [arbvs_pkg::DataW-1:0]         pwdata,
  output logic [arbvs_pkg::DataW-1:0]         prdata,
  output logic                                pready
);
  import arbvs_pkg::*;

  cfg_t    cfg;
  state_t  state_q, state_d;
  result_t res_d, res_q;

  // Input register.
  logic                     in_valid_q, in_valid_d;
  op_e                      op_q;
  logic [MsW-1:0]           elapsed_q;
  logic signed [ValueW-1:0] write_value_q;
  logic                     flag_q;

  logic out_valid_q, out_valid_d;
  logic advance;
  logic in_take;

  arbvs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  arbvs_event_unit u_event (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .op_i           (op_q),
    .elapsed_ms_i   (elapsed_q),
    .write_value_i  (write_value_q),
    .disable_flag_i (flag_q),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  // A buffered request moves on when the result register is free or drains
  // in this same cycle; the input register refills behind it.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  assign in_valid_d  = in_take | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q          <= op_e'(s_axis_tuser);
      elapsed_q     <= s_axis_tdata[MsW-1:0];
      write_value_q <= s_axis_tdata[MsW+ValueW-1:MsW];
      flag_q        <= s_axis_tdata[MsW+ValueW];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutTdataW-ValueW-3){1'b0}}, res_q};

  // A disabled block never keeps a hold armed.
  `ASSERT_NEVER(a_no_hold_when_disabled, clk_i, rst_ni,
                state_q.disabled && (state_q.hold_dir != DIR_NONE))
  // Without a hold the timer and repeat phase stay cleared.
  `ASSERT_PROP(a_idle_timer_clear, clk_i, rst_ni,
               (state_q.hold_dir != DIR_NONE) ||
               ((state_q.hold_timer == '0) && !state_q.repeating))
  // Back-pressure only comes from a full input register.
  `ASSERT_PROP(a_ready_only_when_full, clk_i, rst_ni,
               s_axis_tready || in_valid_q)
  // A result is never both touched and rejected.
  `ASSERT_NEVER(a_touch_excl_status, clk_i, rst_ni,
                out_valid_q && res_q.touched && res_q.status)
  // An unaccepted result stays put until it is taken.
  `ASSERT_PROP(a_result_kept, clk_i, rst_ni,
               (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(res_q)))

endmodule

[tb/sv/stepper_check.sv]
// Checker that predicts and compares every result of the auto-repeat value stepper.
`timescale 1ns / 1ps
module stepper_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // tdata: elapsed_ms[15:0], write_value[47:16], disable_flag[48], zero pad[55:49]
  input  logic [arbvs_pkg::InTdataW-1:0]  s_axis_tdata,
  // tuser: op[3:0]
  input  logic [arbvs_pkg::OpW-1:0]       s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: current_value[31:0], value_changed[32], touched[33], status[34], zero pad[39:35]
  input  logic [arbvs_pkg::OutTdataW-1:0] m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arbvs_pkg::AddrW-1:0]     paddr,
  input  logic [arbvs_pkg::DataW-1:0]     pwdata,
  input  logic [arbvs_pkg::DataW-1:0]     prdata,
  input  logic                            pready,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o
);
  import arbvs_pkg::*;

  // Shadow copy of the registers.
  logic signed [ValueW-1:0] lo_q, hi_q, step_q;
  logic [MsW-1:0]           delay_q, period_q;

  // Shadow copy of the stepper state.
  logic signed [ValueW-1:0] value_q;
  hold_dir_e                dir_q;
  logic [TimerW-1:0]        timer_q;
  logic                     rep_q;
  logic                     off_q;

  // Results owed by the block, oldest first.
  result_t     stepper_results[$];
  int unsigned fail_cnt = 0;
  int unsigned owed_cnt = 0;

  assign errors_o  = fail_cnt;
  assign pending_o = owed_cnt;

  function automatic void drop_hold();
    dir_q   = DIR_NONE;
    timer_q = '0;
    rep_q   = 1'b0;
  endfunction

  task automatic reset_shadow();
    lo_q     = MinReset;
    hi_q     = MaxReset;
    step_q   = StepReset;
    delay_q  = DelayReset;
    period_q = PeriodReset;
    value_q  = '0;
    off_q    = 1'b0;
    drop_hold();
  endtask

  // Lower bound first, then upper, so crossed bounds settle on the upper one.
  function automatic logic signed [ValueW-1:0] fit_bounds(input logic signed [ValueW-1:0] v);
    logic signed [ValueW-1:0] r;
    r = v;
    if (r < lo_q) r = lo_q;
    if (r > hi_q) r = hi_q;
    return r;
  endfunction

  // One step: the sum saturates to the 32-bit range before it is clamped.
  function automatic logic signed [ValueW-1:0] step_value(input logic go_up);
    logic signed [ValueW:0] s;
    if (go_up) begin
      s = $signed({value_q[ValueW-1], value_q}) + $signed({step_q[ValueW-1], step_q});
    end else begin
      s = $signed({value_q[ValueW-1], value_q}) - $signed({step_q[ValueW-1], step_q});
    end
    if (s[ValueW] != s[ValueW-1]) begin
      s[ValueW-1:0] = s[ValueW] ? {1'b1, {(ValueW-1){1'b0}}} : {1'b0, {(ValueW-1){1'b1}}};
    end
    return fit_bounds(s[ValueW-1:0]);
  endfunction

  function automatic result_t next_stepper_result(input logic [OpW-1:0] op,
                                                  input logic [MsW-1:0] el,
                                                  input logic signed [ValueW-1:0] nv,
                                                  input logic fl);
    result_t                  r;
    logic signed [ValueW-1:0] prior;
    logic [TimerW:0]          sum;
    logic [TimerW-1:0]        thr;
    prior = value_q;
    r = '0;
    // Bounds may have moved since the last event.
    value_q = fit_bounds(value_q);
    case (op)
      OP_TICK: begin
        if (off_q) begin
          r.status = 1'b1;
        end else if (dir_q != DIR_NONE) begin
          thr = rep_q ? TimerW'(period_q) : TimerW'(delay_q);
          sum = timer_q + el;
          if (sum > TimerMax) sum = TimerMax;
          timer_q = sum[TimerW-1:0];
          if (timer_q >= thr) begin
            timer_q = '0;
            rep_q   = 1'b1;
            value_q = step_value(dir_q == DIR_UP);
          end
        end
      end
      OP_UP, OP_DOWN: begin
        if (off_q) begin
          r.status = 1'b1;
        end else begin
          r.touched = 1'b1;
          value_q = step_value(op == OP_UP);
        end
      end
      OP_HOME, OP_END: begin
        if (!off_q) begin
          r.touched = 1'b1;
          value_q = fit_bounds((op == OP_HOME) ? lo_q : hi_q);
        end
      end
      OP_HOLD_UP, OP_HOLD_DOWN: begin
        if (off_q) begin
          r.status = 1'b1;
        end else begin
          dir_q   = (op == OP_HOLD_UP) ? DIR_UP : DIR_DOWN;
          timer_q = '0;
          rep_q   = 1'b0;
          value_q = step_value(op == OP_HOLD_UP);
        end
      end
      OP_RELEASE: drop_hold();
      OP_WRITE:   value_q = fit_bounds(nv);
      OP_DISABLE: begin
        off_q = fl;
        if (fl) drop_hold();
      end
      OP_OTHER: begin
        if (!off_q) r.touched = 1'b1;
      end
      default: ;
    endcase
    r.current_value = value_q;
    r.value_changed = (value_q != prior);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t        seen;
    result_t        want;
    logic [DataW-1:0] reg_want;
    logic [DataW-1:0] reg_mask;
    if (!rst_ni) begin
      reset_shadow();
      stepper_results.delete();
      owed_cnt = 0;
    end else begin
      // Register traffic; the stimulus only writes while nothing is in flight.
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[AddrW-1:2]))
            REG_MIN:    lo_q     = pwdata;
            REG_MAX:    hi_q     = pwdata;
            REG_STEP:   step_q   = pwdata;
            REG_DELAY:  delay_q  = pwdata[MsW-1:0];
            REG_PERIOD: period_q = pwdata[MsW-1:0];
            default: ;
          endcase
        end else begin
          reg_want = '0;
          reg_mask = '1;
          case (reg_idx_e'(paddr[AddrW-1:2]))
            REG_MIN:  reg_want = lo_q;
            REG_MAX:  reg_want = hi_q;
            REG_STEP: reg_want = step_q;
            REG_DELAY: begin
              reg_want = DataW'(delay_q);
              reg_mask = DataW'({MsW{1'b1}});
            end
            REG_PERIOD: begin
              reg_want = DataW'(period_q);
              reg_mask = DataW'({MsW{1'b1}});
            end
            default: reg_mask = '0;
          endcase
          if ((prdata & reg_mask) !== (reg_want & reg_mask)) begin
            $error("prdata at %0d: expected %h, got %h", paddr, reg_want, prdata);
            fail_cnt++;
          end
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        seen = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (stepper_results.size() == 0) begin
          $error("result with no request waiting: current_value %0d", seen.current_value);
          fail_cnt++;
        end else begin
          want = stepper_results.pop_front();
          if (seen.current_value !== want.current_value) begin
            $error("current_value: expected %0d, got %0d",
                   want.current_value, seen.current_value);
            fail_cnt++;
          end
          if (seen.value_changed !== want.value_changed) begin
            $error("value_changed: expected %0d, got %0d",
                   want.value_changed, seen.value_changed);
            fail_cnt++;
          end
          if (seen.touched !== want.touched) begin
            $error("touched: expected %0d, got %0d", want.touched, seen.touched);
            fail_cnt++;
          end
          if (seen.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, seen.status);
            fail_cnt++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        stepper_results.push_back(next_stepper_result(s_axis_tuser, s_axis_tdata[15:0],
                                                      s_axis_tdata[47:16], s_axis_tdata[48]));
      end
      owed_cnt = stepper_results.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// Top of the stepper testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module tb;
  import arbvs_pkg::*;

  // One in Q16.16.
  localparam int QOne          = 65536;
  localparam int OpFirstUnused = int'(OP_OTHER) + 1;
  localparam int OpLast        = (1 << OpW) - 1;
  localparam int HoldOffCycles = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]       s_axis_tuser = '0;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire [OutTdataW-1:0]  m_axis_tdata;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrW-1:0]     paddr = '0;
  logic [DataW-1:0]     pwdata = '0;
  wire [DataW-1:0]      prdata;
  wire                  pready;

  int unsigned fail_count;
  int unsigned results_due;

  // Sender and receiver coordination.
  bit no_gaps      = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_off_on  = 1'b0;

  // What the stimulus last programmed, used to aim the random fields.
  logic [ValueW-1:0] cur_lo     = MinReset;
  logic [MsW-1:0]    cur_delay  = DelayReset;
  logic [MsW-1:0]    cur_period = PeriodReset;

  always #10 clk_i = ~clk_i;

  auto_repeat_bounded_value_stepper_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  stepper_check i_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .errors_o      (fail_count),
    .pending_o     (results_due)
  );

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request and returns at the edge that accepts it. tvalid stays
  // high afterwards; the next call or drain_results moves it at the falling edge.
  task automatic send_event(input logic [OpW-1:0] op, input logic [MsW-1:0] el,
                            input logic [ValueW-1:0] nv, input logic fl);
    int gap;
    gap = no_gaps ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= InTdataW'({fl, nv, el});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every owed result has been taken. Since
  // every request yields one result, the block is idle once this returns.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_e idx, input logic [DataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads every register back; the checker compares against its shadow copy.
  task automatic read_all_regs();
    for (int i = 0; i <= int'(REG_PERIOD); i++) begin
      apb_access(1'b0, reg_idx_e'(3'(i)), '0);
    end
  endtask

  // Programs a full setting. The millisecond registers get random upper bits,
  // which the block must drop.
  task automatic program_setting(input logic [ValueW-1:0] lo, input logic [ValueW-1:0] hi,
                                 input logic [ValueW-1:0] stp, input logic [MsW-1:0] dly,
                                 input logic [MsW-1:0] per);
    drain_results();
    apb_access(1'b1, REG_MIN, lo);
    apb_access(1'b1, REG_MAX, hi);
    apb_access(1'b1, REG_STEP, stp);
    apb_access(1'b1, REG_DELAY, {16'($urandom), dly});
    apb_access(1'b1, REG_PERIOD, {16'($urandom), per});
    cur_lo     = lo;
    cur_delay  = dly;
    cur_period = per;
    read_all_regs();
  endtask

  // Random event mix. Ticks dominate, so an armed hold usually runs into its
  // repeats before a release or another hold breaks it up.
  task automatic random_event();
    int                r;
    int                pick;
    logic [OpW-1:0]    op;
    logic [MsW-1:0]    el;
    logic [ValueW-1:0] nv;
    logic              fl;
    r    = $urandom_range(0, 99);
    pick = $urandom_range(0, 1);
    fl   = ($urandom_range(0, 9) < 3);
    nv   = ($urandom_range(0, 1) != 0) ? $urandom : cur_lo + ValueW'($urandom_range(0, 16 * QOne));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        el = MsW'($urandom_range(0, int'(cur_delay) / 4 + int'(cur_period) + 4));
      end
      6, 7, 8:          el = MsW'($urandom_range(0, int'(cur_delay) + 8));
      default:          el = MsW'($urandom);
    endcase
    if (r < 12)      op = pick ? OP_UP : OP_DOWN;
    else if (r < 20) op = pick ? OP_HOLD_UP : OP_HOLD_DOWN;
    else if (r < 25) op = OP_RELEASE;
    else if (r < 30) op = pick ? OP_HOME : OP_END;
    else if (r < 37) op = OP_WRITE;
    else if (r < 41) op = OP_DISABLE;
    else if (r < 45) op = OP_OTHER;
    else if (r < 48) op = OpW'($urandom_range(OpFirstUnused, OpLast));
    else             op = OP_TICK;
    send_event(op, el, nv, fl);
  endtask

  // Receiver: random stretches of ready and stall. On request it holds ready
  // low so that the block fills and stalls input.
  initial begin : receiver
    int  r;
    int  n;
    bit  lvl;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_off_on  = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_on = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          lvl = 1'b1;
          n   = $urandom_range(30, 80);
        end else if (r < 60) begin
          lvl = 1'b1;
          n   = $urandom_range(1, 6);
        end else if (r < 90) begin
          lvl = 1'b0;
          n   = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          n   = $urandom_range(10, 40);
        end
        m_axis_tready <= lvl;
        repeat (n) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [ValueW-1:0] lo;
    logic [ValueW-1:0] hi;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers must come out of reset at their documented values.
    read_all_regs();

    // Directed walk through every event with the reset setting: bounds 0 and
    // 100.0, step 1.0, 500 ms initial delay, 50 ms repeat period.
    send_event(OP_OTHER, '0, '0, 1'b0);
    send_event(OP_UP, '0, '0, 1'b0);
    send_event(OP_DOWN, '0, '0, 1'b0);
    send_event(OP_DOWN, 16'hFFFF, '1, 1'b1);           // pinned at the lower bound
    send_event(OP_END, '0, '0, 1'b0);
    send_event(OP_UP, '0, '0, 1'b0);                   // pinned at the upper bound
    send_event(OP_HOME, '0, '0, 1'b0);
    send_event(OP_WRITE, '0, 32'h7FFF_FFFF, 1'b0);     // write is clamped
    send_event(OP_WRITE, '0, 32'h8000_0000, 1'b0);
    send_event(OP_HOLD_UP, '0, '0, 1'b0);
    send_event(OP_TICK, 16'd499, '0, 1'b0);            // one short of the delay
    send_event(OP_TICK, 16'd1, '0, 1'b0);              // first repeat
    send_event(OP_TICK, 16'd49, '0, 1'b0);
    send_event(OP_TICK, 16'd1, '0, 1'b0);              // second repeat
    send_event(OP_TICK, 16'hFFFF, '0, 1'b0);
    send_event(OP_RELEASE, '0, '0, 1'b0);
    send_event(OP_TICK, 16'hFFFF, '0, 1'b0);           // tick with nothing held
    send_event(OP_HOLD_DOWN, '0, '0, 1'b0);
    send_event(OP_DISABLE, '0, '0, 1'b1);              // also drops the hold
    send_event(OP_UP, '0, '0, 1'b0);                   // rejected
    send_event(OP_HOME, '0, '0, 1'b0);                 // ignored
    send_event(OP_TICK, 16'd600, '0, 1'b0);            // rejected
    send_event(OP_HOLD_UP, '0, '0, 1'b0);              // rejected
    send_event(OP_OTHER, '0, '0, 1'b0);                // ignored
    send_event(OP_WRITE, '0, 32'(50 * QOne), 1'b0);    // write acts while disabled
    send_event(OP_RELEASE, '0, '0, 1'b0);
    send_event(OpW'(OpLast), '0, '0, 1'b0);
    send_event(OP_DISABLE, '0, '0, 1'b0);
    send_event(OpW'(OpFirstUnused), '0, '0, 1'b0);

    // Narrowing the bounds re-clamps the held value on the next event, and a
    // zero delay and period repeat on every tick, even with zero elapsed time.
    program_setting(32'(10 * QOne), 32'(20 * QOne), 32'(QOne), '0, '0);
    send_event(OP_OTHER, '0, '0, 1'b0);
    send_event(OP_HOLD_DOWN, '0, '0, 1'b0);
    send_event(OP_TICK, '0, '0, 1'b0);
    send_event(OP_TICK, '0, '0, 1'b0);
    send_event(OP_RELEASE, '0, '0, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        // Widest bounds and the largest step: sums saturate.
        0: program_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd100, 16'd20);
        // Crossed bounds and the most negative step.
        1: program_setting(32'(50 * QOne), -32'(50 * QOne), 32'h8000_0000, 16'd30, 16'd5);
        // Narrow bounds, quarter step, repeats on every tick.
        2: program_setting(-32'(5 * QOne), 32'(5 * QOne), 32'(QOne / 4), '0, '0);
        // Longest delays.
        3: program_setting(32'h8000_0000, 32'(3 * QOne), $urandom, 16'hFFFF, 16'hFFFF);
        default: begin
          lo = $urandom;
          hi = $urandom;
          if (($urandom_range(0, 3) != 0) && ($signed(lo) > $signed(hi))) begin
            {lo, hi} = {hi, lo};
          end
          program_setting(lo, hi, $urandom >> $urandom_range(0, 20),
                          16'($urandom_range(0, 300)), 16'($urandom_range(0, 60)));
        end
      endcase
      repeat (95) random_event();

      if (ph == 2) begin
        // Receiver holds off while requests keep coming at full rate, then the
        // sender waits for every result before going on.
        drain_results();
        hold_off_req = 1'b1;
        wait (hold_off_on);
        no_gaps = 1'b1;
        repeat (30) random_event();
        no_gaps = 1'b0;
        drain_results();
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
